FILE: hdl/psra_pkg.sv
// Shared types, constants and control structs for the paged shelf rectangle allocator.
// Used by psra_ctrl, psra_dpath and paged_shelf_rect_allocator; no dependencies.
package psra_pkg;

    localparam int PAGE_SIZE_DEF = 1024;
    localparam int MAX_PAGES_DEF = 8;
    localparam int PADDING_DEF   = 1;

    // request field width and padded size width (4095 plus up to 4096 of padding)
    localparam int RECT_W  = 12;
    localparam int REQ_W   = 13;
    localparam int LIMIT_W = 4;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd8;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_PAD_W  = 7;

    typedef logic [9:0] coord_out_t;
    typedef logic [2:0] page_out_t;
    typedef logic [7:0] count_cmp_t;

    // result selection codes
    localparam logic [1:0] RES_PLACE = 2'd0;
    localparam logic [1:0] RES_OPEN  = 2'd1;
    localparam logic [1:0] RES_FAIL  = 2'd2;

    typedef struct packed {
        logic       load_req;
        logic       scan_page;
        logic       step;
        logic       open_page;
        logic       res_take;
        logic [1:0] res_sel;
        logic       load_out;
    } psra_cmd_t;

    typedef struct packed {
        logic oversize;
        logic at_end;
        logic can_open;
        logic kind_match;
        logic fits;
    } psra_stat_t;

endpackage

FILE: hdl/psra_ctrl.sv
// Controller state machine for the rectangle allocator: handshakes and scan sequencing.
// Depends on psra_pkg for the command and status structs and result codes.
module psra_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  psra_pkg::psra_stat_t  stat,
    output psra_pkg::psra_cmd_t   cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_RESULT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.res_sel  = psra_pkg::RES_FAIL;
        m_valid_next = m_valid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (stat.oversize) begin
                    cmd.res_take = 1'b1;
                    cmd.res_sel  = psra_pkg::RES_FAIL;
                    state_next   = ST_RESULT;
                end else if (stat.at_end) begin
                    // every open page tried, open a fresh one if allowed
                    cmd.res_take = 1'b1;
                    if (stat.can_open) begin
                        cmd.open_page = 1'b1;
                        cmd.res_sel   = psra_pkg::RES_OPEN;
                    end else begin
                        cmd.res_sel   = psra_pkg::RES_FAIL;
                    end
                    state_next = ST_RESULT;
                end else if (stat.kind_match) begin
                    cmd.scan_page = 1'b1;
                    if (stat.fits) begin
                        cmd.res_take = 1'b1;
                        cmd.res_sel  = psra_pkg::RES_PLACE;
                        state_next   = ST_RESULT;
                    end else begin
                        cmd.step = 1'b1;
                    end
                end else begin
                    cmd.step = 1'b1;
                end
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

endmodule

FILE: hdl/psra_dpath.sv
// Datapath for the rectangle allocator: page records, request and scan registers,
// shelf arithmetic and the output item register. Depends on psra_pkg.
module psra_dpath #(
    parameter int PAGE_SIZE = psra_pkg::PAGE_SIZE_DEF,
    parameter int MAX_PAGES = psra_pkg::MAX_PAGES_DEF,
    parameter int PADDING   = psra_pkg::PADDING_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [psra_pkg::IN_DATA_W-1:0]       s_tdata,
    input  logic                                 s_tuser,
    input  logic                                 cfg_we,
    input  logic [psra_pkg::LIMIT_W-1:0]         cfg_wdata,
    input  psra_pkg::psra_cmd_t                  cmd,
    output psra_pkg::psra_stat_t                 stat,
    output logic [psra_pkg::OUT_DATA_W-1:0]      m_tdata
);

    localparam int RECT_W = psra_pkg::RECT_W;
    localparam int REQ_W  = psra_pkg::REQ_W;
    localparam int CW     = $clog2(PAGE_SIZE + 1);
    localparam int S_W    = ((CW > REQ_W) ? CW : REQ_W) + 1;
    localparam int CNT_W  = $clog2(MAX_PAGES + 1);
    localparam int PG_W   = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;

    typedef logic [CW-1:0] coord_t;

    logic [REQ_W-1:0]            req_w_reg;
    logic [REQ_W-1:0]            req_h_reg;
    logic                        req_kind_reg;
    logic [CNT_W-1:0]            idx_reg;
    logic [CNT_W-1:0]            pages_open_reg;
    logic [psra_pkg::LIMIT_W-1:0] limit_reg;

    logic   colour_reg [MAX_PAGES];
    coord_t pen_reg    [MAX_PAGES];
    coord_t top_reg    [MAX_PAGES];
    coord_t tall_reg   [MAX_PAGES];

    logic                 res_placed_reg;
    psra_pkg::page_out_t  res_page_reg;
    psra_pkg::coord_out_t res_x_reg;
    psra_pkg::coord_out_t res_y_reg;
    logic                 res_opened_reg;
    logic [psra_pkg::OUT_DATA_W-1:0] out_data_reg;

    logic [PG_W-1:0] pg;
    coord_t          cur_pen;
    coord_t          cur_top;
    coord_t          cur_tall;
    logic [S_W-1:0]  pen_sum;
    logic [S_W-1:0]  top_adv;
    logic [S_W-1:0]  top_sum;
    logic [S_W-1:0]  place_sum;
    logic            wrap;
    logic            fits;
    coord_t          eff_pen;
    coord_t          eff_top;
    coord_t          eff_tall;
    coord_t          h_cw;
    coord_t          w_cw;
    coord_t          new_pen;
    coord_t          new_tall;
    psra_pkg::count_cmp_t lim_ext;
    psra_pkg::count_cmp_t lim_eff;

    assign pg       = idx_reg[PG_W-1:0];
    assign cur_pen  = pen_reg[pg];
    assign cur_top  = top_reg[pg];
    assign cur_tall = tall_reg[pg];
    assign h_cw     = CW'(req_h_reg);
    assign w_cw     = CW'(req_w_reg);

    always_comb begin
        pen_sum   = S_W'(cur_pen) + S_W'(req_w_reg);
        wrap      = pen_sum > S_W'(PAGE_SIZE);
        // starting a new shelf drops below the tallest item of the old one
        top_adv   = S_W'(cur_top) + S_W'(cur_tall);
        eff_top   = wrap ? CW'(top_adv) : cur_top;
        eff_pen   = wrap ? '0 : cur_pen;
        eff_tall  = wrap ? '0 : cur_tall;
        top_sum   = S_W'(eff_top) + S_W'(req_h_reg);
        place_sum = S_W'(eff_pen) + S_W'(req_w_reg);
        fits      = top_sum <= S_W'(PAGE_SIZE);
        new_pen   = fits ? CW'(place_sum) : eff_pen;
        if (fits && (h_cw > eff_tall)) begin
            new_tall = h_cw;
        end else begin
            new_tall = eff_tall;
        end
    end

    always_comb begin
        lim_ext = psra_pkg::count_cmp_t'(limit_reg);
        if (lim_ext > psra_pkg::count_cmp_t'(MAX_PAGES)) begin
            lim_eff = psra_pkg::count_cmp_t'(MAX_PAGES);
        end else begin
            lim_eff = lim_ext;
        end
    end

    assign stat.fits       = fits;
    assign stat.oversize   = (req_w_reg > REQ_W'(PAGE_SIZE)) || (req_h_reg > REQ_W'(PAGE_SIZE));
    assign stat.at_end     = (idx_reg == pages_open_reg);
    assign stat.can_open   = psra_pkg::count_cmp_t'(pages_open_reg) < lim_eff;
    assign stat.kind_match = (colour_reg[pg] == req_kind_reg);

    // configuration, request and scan index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= psra_pkg::LIMIT_RESET;
        end else if (cfg_we) begin
            limit_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_w_reg    <= REQ_W'(s_tdata[RECT_W-1:0]) + REQ_W'(2 * PADDING);
            req_h_reg    <= REQ_W'(s_tdata[2*RECT_W-1:RECT_W]) + REQ_W'(2 * PADDING);
            req_kind_reg <= s_tuser;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else if (cmd.load_req) begin
            idx_reg <= '0;
        end else if (cmd.step) begin
            idx_reg <= idx_reg + CNT_W'(1);
        end
    end

    // page records; page 0 starts open as a coverage page
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pages_open_reg <= CNT_W'(1);
            for (int k = 0; k < MAX_PAGES; k++) begin
                colour_reg[k] <= 1'b0;
                pen_reg[k]    <= '0;
                top_reg[k]    <= '0;
                tall_reg[k]   <= '0;
            end
        end else if (cmd.open_page) begin
            pages_open_reg <= pages_open_reg + CNT_W'(1);
            colour_reg[pg] <= req_kind_reg;
            pen_reg[pg]    <= w_cw;
            top_reg[pg]    <= '0;
            tall_reg[pg]   <= h_cw;
        end else if (cmd.scan_page) begin
            // shelf change is kept even when the page proves too short
            pen_reg[pg]  <= new_pen;
            top_reg[pg]  <= eff_top;
            tall_reg[pg] <= new_tall;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_take) begin
            case (cmd.res_sel)
                psra_pkg::RES_PLACE: begin
                    res_placed_reg <= 1'b1;
                    res_page_reg   <= psra_pkg::page_out_t'(idx_reg);
                    res_x_reg      <= psra_pkg::coord_out_t'(S_W'(eff_pen) + S_W'(PADDING));
                    res_y_reg      <= psra_pkg::coord_out_t'(S_W'(eff_top) + S_W'(PADDING));
                    res_opened_reg <= 1'b0;
                end
                psra_pkg::RES_OPEN: begin
                    res_placed_reg <= 1'b1;
                    res_page_reg   <= psra_pkg::page_out_t'(idx_reg);
                    res_x_reg      <= psra_pkg::coord_out_t'(PADDING);
                    res_y_reg      <= psra_pkg::coord_out_t'(PADDING);
                    res_opened_reg <= 1'b1;
                end
                default: begin
                    res_placed_reg <= 1'b0;
                    res_page_reg   <= '0;
                    res_x_reg      <= '0;
                    res_y_reg      <= '0;
                    res_opened_reg <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_data_reg <= {{psra_pkg::OUT_PAD_W{1'b0}}, res_opened_reg, res_y_reg,
                             res_x_reg, res_page_reg, res_placed_reg};
        end
    end

    assign m_tdata = out_data_reg;

endmodule

FILE: hdl/paged_shelf_rect_allocator.sv
// channel | direction | tdata fields (low bit up)                        | tuser
// s_      | in        | rect_width[11:0], rect_height[23:12]             | colour_kind
// m_      | out       | placed, page_index, origin_x, origin_y, opened_page | -
// cfg_    | in        | page_limit on cfg_wdata, written when cfg_we is high | -
//
// one item at a time: the item is accepted, then the open page records are visited in turn
// (up to MAX_PAGES, one record read per cycle), a fresh page is opened or the request
// fails, and the result is moved to the output register.
// oversized requests fail before any page is visited. the next item is accepted while a
// result still waits on m_tready. reset is synchronous on aresetn low: page 0 open
// as a coverage page, page_limit 8; no clearing pass.
// Top level of the allocator; depends on psra_pkg, psra_ctrl and psra_dpath.
module paged_shelf_rect_allocator #(
    parameter int PAGE_SIZE = psra_pkg::PAGE_SIZE_DEF,
    parameter int MAX_PAGES = psra_pkg::MAX_PAGES_DEF,
    parameter int PADDING   = psra_pkg::PADDING_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [psra_pkg::IN_DATA_W-1:0]   s_tdata,   // rect_width, rect_height
    input  logic                             s_tuser,   // colour_kind
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [psra_pkg::OUT_DATA_W-1:0]  m_tdata,   // placed, page_index, origin_x,
                                                        // origin_y, opened_page, zero fill
    input  logic                             cfg_we,
    input  logic [psra_pkg::LIMIT_W-1:0]     cfg_wdata
);

    psra_pkg::psra_cmd_t  cmd;
    psra_pkg::psra_stat_t stat;

    psra_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    psra_dpath #(
        .PAGE_SIZE (PAGE_SIZE),
        .MAX_PAGES (MAX_PAGES),
        .PADDING   (PADDING)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tdata   (m_tdata)
    );

endmodule
